### sv/mms_pkg.sv
// Shared types and codes for the min/max stack.
`default_nettype none

package mms_pkg;

  // Operation code carried in each input word.
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  // Status code returned with each result word.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } mms_shift_t;

endpackage

`default_nettype wire

### sv/mms_in_if.sv
// Input channel of the min/max stack: operation and value to push.
`default_nettype none

interface mms_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [31:0] push_value;

  modport source (output valid, output operation, output push_value, input ready);
  modport sink   (input valid, input operation, input push_value, output ready);
endinterface

`default_nettype wire

### sv/mms_out_if.sv
// Result channel of the min/max stack: top, minimum, maximum and flags.
`default_nettype none

interface mms_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] top_value;
  logic signed [31:0] min_value;
  logic signed [31:0] max_value;
  logic               is_empty;
  logic [1:0]         status;

  modport source (output valid, output top_value, output min_value, output max_value,
                  output is_empty, output status, input ready);
  modport sink   (input valid, input top_value, input min_value, input max_value,
                  input is_empty, input status, output ready);
endinterface

`default_nettype wire

### sv/mms_cell.sv
// One stack level: value with running minimum and maximum, shifting to either neighbor.
`default_nettype none

module mms_cell
  import mms_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire                    clk,
  input  mms_shift_t             shift,
  input  wire [DATA_WIDTH-1:0]   up_val,
  input  wire [DATA_WIDTH-1:0]   up_min,
  input  wire [DATA_WIDTH-1:0]   up_max,
  input  wire [DATA_WIDTH-1:0]   dn_val,
  input  wire [DATA_WIDTH-1:0]   dn_min,
  input  wire [DATA_WIDTH-1:0]   dn_max,
  output logic [DATA_WIDTH-1:0]  val_r,
  output logic [DATA_WIDTH-1:0]  min_r,
  output logic [DATA_WIDTH-1:0]  max_r
);

  // A push takes the entry from the level above, a pop from the level below.
  always_ff @(posedge clk) begin
    if (shift.push) begin
      val_r <= up_val;
      min_r <= up_min;
      max_r <= up_max;
    end else if (shift.pop) begin
      val_r <= dn_val;
      min_r <= dn_min;
      max_r <= dn_max;
    end
  end

endmodule

`default_nettype wire

### sv/min_max_stack.sv
// Top level of the min/max stack: a shifting chain of levels plus the result register.
//
//   Channel  Direction  Handshake        Payload
//   in_ch    sink       valid / ready    operation, push_value
//   out_ch   source     valid / ready    top_value, min_value, max_value, is_empty, status
//
// One word is taken per cycle while in_ch.ready is high; its result word is registered
// in the output register at acceptance, at the same edge that updates the cell chain.
// in_ch.ready is high while the output register is empty or being drained, so a
// stalled consumer holds off new words only once a result is waiting.
// rst_n (synchronous, active low) clears the entry count and the output valid flag;
// stored levels are not cleared since only occupied levels are ever read.
`default_nettype none

module min_max_stack
  import mms_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire       clk,
  input  wire       rst_n,
  mms_in_if.sink    in_ch,
  mms_out_if.source out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // Level 0 is always the top of the stack; deeper entries sit at higher indexes.
  logic [DATA_WIDTH-1:0] cell_val [DEPTH];
  logic [DATA_WIDTH-1:0] cell_min [DEPTH];
  logic [DATA_WIDTH-1:0] cell_max [DEPTH];
  logic [DATA_WIDTH-1:0] up_val   [DEPTH];
  logic [DATA_WIDTH-1:0] up_min   [DEPTH];
  logic [DATA_WIDTH-1:0] up_max   [DEPTH];
  logic [DATA_WIDTH-1:0] dn_val   [DEPTH];
  logic [DATA_WIDTH-1:0] dn_min   [DEPTH];
  logic [DATA_WIDTH-1:0] dn_max   [DEPTH];

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic             accept;
  logic             is_pop;
  logic             stack_empty;
  logic             stack_full;
  mms_shift_t       shift;
  status_t          status_nxt;

  logic [DATA_WIDTH-1:0] new_val;
  logic [DATA_WIDTH-1:0] new_min;
  logic [DATA_WIDTH-1:0] new_max;
  logic [DATA_WIDTH-1:0] top_val_nxt;
  logic [DATA_WIDTH-1:0] top_min_nxt;
  logic [DATA_WIDTH-1:0] top_max_nxt;

  logic               out_valid_r;
  logic signed [31:0] out_top_r;
  logic signed [31:0] out_min_r;
  logic signed [31:0] out_max_r;
  logic               out_empty_r;
  status_t            out_status_r;

  // The result register frees as soon as the consumer takes its word.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_pop      = (op_t'(in_ch.operation) == OP_POP);

  assign stack_empty = (count_r == '0);
  assign stack_full  = (count_r == CNT_W'(DEPTH));

  // The pushed word is sign-extended (or truncated) to the storage width. Its level
  // minimum and maximum fold in those of the current top, when there is one.
  always_comb begin
    new_val = DATA_WIDTH'(in_ch.push_value);
    new_min = new_val;
    new_max = new_val;
    if (!stack_empty) begin
      if ($signed(cell_min[0]) < $signed(new_val)) begin
        new_min = cell_min[0];
      end
      if ($signed(new_val) < $signed(cell_max[0])) begin
        new_max = cell_max[0];
      end
    end
  end

  // Refused operations leave the chain and the count untouched.
  always_comb begin
    shift.push = 1'b0;
    shift.pop  = 1'b0;
    status_nxt = ST_OK;
    count_nxt  = count_r;
    if (accept) begin
      if (!is_pop) begin
        if (stack_full) begin
          status_nxt = ST_FULL;
        end else begin
          shift.push = 1'b1;
          count_nxt  = count_r + CNT_W'(1);
        end
      end else begin
        if (stack_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          shift.pop = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
    end
  end

  // Neighbor wiring: the head is fed by the pushed entry, the tail by zeros.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) begin
        up_val[i] = new_val;
        up_min[i] = new_min;
        up_max[i] = new_max;
      end else begin
        up_val[i] = cell_val[i-1];
        up_min[i] = cell_min[i-1];
        up_max[i] = cell_max[i-1];
      end
      if (i == DEPTH - 1) begin
        dn_val[i] = '0;
        dn_min[i] = '0;
        dn_max[i] = '0;
      end else begin
        dn_val[i] = cell_val[i+1];
        dn_min[i] = cell_min[i+1];
        dn_max[i] = cell_max[i+1];
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    mms_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk    (clk),
      .shift  (shift),
      .up_val (up_val[g]),
      .up_min (up_min[g]),
      .up_max (up_max[g]),
      .dn_val (dn_val[g]),
      .dn_min (dn_min[g]),
      .dn_max (dn_max[g]),
      .val_r  (cell_val[g]),
      .min_r  (cell_min[g]),
      .max_r  (cell_max[g])
    );
  end

  // The top after this word is what level 0 will hold at the next edge.
  always_comb begin
    if (shift.push) begin
      top_val_nxt = new_val;
      top_min_nxt = new_min;
      top_max_nxt = new_max;
    end else if (shift.pop) begin
      top_val_nxt = dn_val[0];
      top_min_nxt = dn_min[0];
      top_max_nxt = dn_max[0];
    end else begin
      top_val_nxt = cell_val[0];
      top_min_nxt = cell_min[0];
      top_max_nxt = cell_max[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Reported words are the low 32 bits of the stored words; an empty stack reads zero.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_nxt;
      if (count_nxt == '0) begin
        out_top_r   <= '0;
        out_min_r   <= '0;
        out_max_r   <= '0;
        out_empty_r <= 1'b1;
      end else begin
        out_top_r   <= 32'(top_val_nxt);
        out_min_r   <= 32'(top_min_nxt);
        out_max_r   <= 32'(top_max_nxt);
        out_empty_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.top_value = out_top_r;
  assign out_ch.min_value = out_min_r;
  assign out_ch.max_value = out_max_r;
  assign out_ch.is_empty  = out_empty_r;
  assign out_ch.status    = out_status_r;

endmodule

`default_nettype wire

### sv/mms_chk.sv
// Port-level checks of the min/max stack, bound to its top level.
`default_nettype none

module mms_chk
  import mms_pkg::*;
(
  input wire               clk,
  input wire               rst_n,
  input wire               in_valid,
  input wire               in_ready,
  input wire               out_valid,
  input wire               out_ready,
  input wire signed [31:0] top_value,
  input wire signed [31:0] min_value,
  input wire signed [31:0] max_value,
  input wire               is_empty,
  input wire [1:0]         status
);

  // Every accepted word yields a result word on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after an accepted word");

  // A waiting result is held until taken.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(top_value) && $stable(min_value)
      && $stable(max_value) && $stable(is_empty) && $stable(status))
    else $error("waiting result changed");

  // An empty stack reports all values as zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_empty |-> top_value == 0 && min_value == 0 && max_value == 0)
    else $error("empty stack reports nonzero values");

  // The top lies between the minimum and maximum of the stored words.
  a_top_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_empty |-> min_value <= top_value && top_value <= max_value)
    else $error("top outside minimum and maximum");

  // A refused pop only happens on an empty stack, and no unused status code appears.
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == ST_OK || status == ST_FULL || (status == ST_EMPTY && is_empty)))
    else $error("illegal status");

endmodule

bind min_max_stack mms_chk u_mms_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .top_value (out_ch.top_value),
  .min_value (out_ch.min_value),
  .max_value (out_ch.max_value),
  .is_empty  (out_ch.is_empty),
  .status    (out_ch.status)
);

`default_nettype wire

### bench/tb_top.sv
// Self-checking testbench for the min/max stack: random and directed push/pop traffic.
`timescale 1ns / 1ps

module tb_top;
  import mms_pkg::*;

  // The block is built at its default size; the bench models the same stack.
  localparam int STACK_DEPTH = 16;
  localparam int HALF_PERIOD = 6;
  localparam int HOLD_CYCLES = 64;
  localparam int PHASE_WORDS = 250;

  localparam logic signed [31:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic signed [31:0] WORD_MIN = 32'h8000_0000;

  // One input word as the sender queues it.
  typedef struct {
    op_t                op;
    logic signed [31:0] value;
  } stack_cmd_t;

  // What the stack should report after one word.
  typedef struct {
    logic [31:0] top;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        empty;
    status_t     st;
  } stack_view_t;

  logic clk = 1'b0;
  logic rst_n;

  mms_in_if  in_if ();
  mms_out_if out_if ();

  min_max_stack #(
    .DEPTH      (STACK_DEPTH),
    .DATA_WIDTH (32)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #HALF_PERIOD clk = ~clk;

  // Words waiting to be offered, and views the stack still owes us.
  stack_cmd_t  pending_cmds[$];
  stack_view_t views_due[$];
  stack_cmd_t  next_cmd;
  stack_view_t want_view;

  // Shadow copy of the stack. Each level keeps its value together with the
  // running minimum and maximum of itself and every level below it, so a pop
  // restores the previous extremes for free and duplicates count separately.
  logic signed [31:0] level_value[STACK_DEPTH];
  logic signed [31:0] level_min[STACK_DEPTH];
  logic signed [31:0] level_max[STACK_DEPTH];
  int unsigned        level_count = 0;

  // Idle mix of the current phase, in percent.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Long receiver hold: the stimulus asks by bumping hold_req, and the hold
  // process below counts the cycles on its own.
  int hold_req  = 0;
  int hold_ack  = 0;
  int hold_left = 0;

  // Depth of the stack as the stimulus generator sees it, used to shape
  // fill and drain runs.
  int gen_depth   = 0;
  int queued_cmds = 0;

  int mismatches    = 0;
  int views_checked = 0;
  int pushes_taken  = 0;
  int pops_taken    = 0;
  int full_refusals = 0;
  int empty_refusals = 0;

  // Applies one word to the shadow stack and returns what the block should show.
  function automatic stack_view_t apply_stack_op(op_t op, logic signed [31:0] v);
    stack_view_t        view;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    view.st = ST_OK;
    if (op == OP_PUSH) begin
      if (level_count >= STACK_DEPTH) begin
        view.st = ST_FULL;
        full_refusals++;
      end else begin
        lo = v;
        hi = v;
        if (level_count > 0) begin
          if (level_min[level_count - 1] < lo) lo = level_min[level_count - 1];
          if (level_max[level_count - 1] > hi) hi = level_max[level_count - 1];
        end
        level_value[level_count] = v;
        level_min[level_count]   = lo;
        level_max[level_count]   = hi;
        level_count++;
        pushes_taken++;
      end
    end else begin
      if (level_count == 0) begin
        view.st = ST_EMPTY;
        empty_refusals++;
      end else begin
        level_count--;
        pops_taken++;
      end
    end
    // An empty stack reports zeros with the empty flag set.
    if (level_count == 0) begin
      view.top   = '0;
      view.lo    = '0;
      view.hi    = '0;
      view.empty = 1'b1;
    end else begin
      view.top   = level_value[level_count - 1];
      view.lo    = level_min[level_count - 1];
      view.hi    = level_max[level_count - 1];
      view.empty = 1'b0;
    end
    return view;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= 30)
      $display("mismatch at result %0d: %s got %h, want %h", views_checked, what, got, want);
  endtask

  // Queues one word and keeps the generator's idea of the depth in step.
  task automatic add_cmd(input op_t op, input logic signed [31:0] v);
    stack_cmd_t c;
    c.op    = op;
    c.value = v;
    pending_cmds.push_back(c);
    queued_cmds++;
    if (op == OP_PUSH && gen_depth < STACK_DEPTH) gen_depth++;
    if (op == OP_POP && gen_depth > 0) gen_depth--;
  endtask

  // Values lean toward the extremes and a narrow band around zero, so that
  // equal values and ties on the minimum and maximum come up often.
  function automatic logic signed [31:0] pick_value();
    int band;
    band = $urandom_range(0, 15);
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2, 3, 4: return band - 8;
      default: return $urandom;
    endcase
  endfunction

  // One run of words: a fill past full, a drain to empty or past it, or a random mix.
  // The words past the ends are the refused pushes and pops.
  task automatic add_sequence();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      while (gen_depth < STACK_DEPTH) add_cmd(OP_PUSH, pick_value());
      repeat ($urandom_range(1, 2)) add_cmd(OP_PUSH, pick_value());
    end else if (kind <= 5) begin
      while (gen_depth > 0) add_cmd(OP_POP, pick_value());
      repeat ($urandom_range(0, 2)) add_cmd(OP_POP, pick_value());
    end else begin
      n = $urandom_range(4, 20);
      repeat (n) add_cmd(($urandom_range(0, 99) < 55) ? OP_PUSH : OP_POP, pick_value());
    end
  endtask

  task automatic add_random_words(input int count);
    int target;
    target = queued_cmds + count;
    while (queued_cmds < target) add_sequence();
  endtask

  // Holds the sender back until every word has been taken and answered.
  // The state is looked at on the falling edge, once the rising edge has settled.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_cmds.size() != 0 || in_if.valid || views_due.size() != 0)
      @(negedge clk);
  endtask

  // Sender. A word stays on the channel until it is taken; at that edge the
  // prediction is made and the next word, or an idle cycle, is put up.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready)
        views_due.push_back(apply_stack_op(op_t'(in_if.operation), in_if.push_value));
      if (!in_if.valid || in_if.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_cmd = pending_cmds.pop_front();
          in_if.valid      <= 1'b1;
          in_if.operation  <= next_cmd.op;
          in_if.push_value <= next_cmd.value;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Counts out a long receiver hold whenever one is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_req;
    end
  end

  // Receiver: random stalls, and a full stall while a long hold runs.
  always @(posedge clk) begin
    if (!rst_n)
      out_if.ready <= 1'b0;
    else
      out_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Checker: each result word is held against the oldest expected view.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (views_due.size() == 0) begin
        flag_mismatch("result with nothing pending, top_value", out_if.top_value, '0);
      end else begin
        want_view = views_due.pop_front();
        if (out_if.top_value !== want_view.top)
          flag_mismatch("top_value", out_if.top_value, want_view.top);
        if (out_if.min_value !== want_view.lo)
          flag_mismatch("min_value", out_if.min_value, want_view.lo);
        if (out_if.max_value !== want_view.hi)
          flag_mismatch("max_value", out_if.max_value, want_view.hi);
        if (out_if.is_empty !== want_view.empty)
          flag_mismatch("is_empty", 32'(out_if.is_empty), 32'(want_view.empty));
        if (out_if.status !== want_view.st)
          flag_mismatch("status", 32'(out_if.status), 32'(want_view.st));
      end
      views_checked++;
    end
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.operation  = OP_PUSH;
    in_if.push_value = '0;
    out_if.ready     = 1'b0;
    rst_n            = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one runs without idling. The receiver holds off for a long
    // stretch right away, so the single result register fills and the
    // block must stall its input while the directed words wait.
    hold_req = hold_req + 1;

    // Directed words: a pop on the empty stack, both extremes, a repeated
    // minimum and a repeated small value, then a fill to the top, a push
    // that is refused because the stack is full, and a few pops that must
    // keep the repeated minimum in place.
    add_cmd(OP_POP, 32'sd5);
    add_cmd(OP_PUSH, WORD_MAX);
    add_cmd(OP_PUSH, WORD_MIN);
    add_cmd(OP_PUSH, WORD_MIN);
    add_cmd(OP_PUSH, 32'sd0);
    add_cmd(OP_PUSH, -32'sd1);
    add_cmd(OP_PUSH, 32'sd1);
    add_cmd(OP_PUSH, 32'sd1);
    repeat (STACK_DEPTH - 7) add_cmd(OP_PUSH, pick_value());
    add_cmd(OP_PUSH, WORD_MAX);
    repeat (3) add_cmd(OP_POP, 32'sd0);

    // Halfway through the random words the sender waits for every result.
    add_random_words(PHASE_WORDS / 2);
    wait_drained();
    add_random_words(PHASE_WORDS / 2);
    wait_drained();

    // Sender mostly idle.
    send_idle_pct = 86;
    add_random_words(PHASE_WORDS);
    wait_drained();

    // Receiver mostly stalled.
    send_idle_pct  = 0;
    recv_stall_pct = 86;
    add_random_words(PHASE_WORDS);
    wait_drained();

    // Both sides idle about a third of the time.
    send_idle_pct  = 36;
    recv_stall_pct = 36;
    add_random_words(PHASE_WORDS);
    wait_drained();

    // Each result is registered on acceptance; this wait catches any strays.
    repeat (8) @(posedge clk);

    $display("Ran %0d words: %0d pushes, %0d pops, %0d refused when full, %0d when empty.",
             queued_cmds, pushes_taken, pops_taken, full_refusals, empty_refusals);
    $display("Idle mixes none, sender, receiver and both; %0d results checked, %0d bad.",
             views_checked, mismatches);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
sv/mms_pkg.sv
sv/mms_in_if.sv
sv/mms_out_if.sv
sv/mms_cell.sv
sv/min_max_stack.sv
sv/mms_chk.sv
bench/tb_top.sv
